/* src/lbp_pkg.sv */
// Shared constants and types for the local binary pattern window coder.
`timescale 1ns / 1ps

package lbp_pkg;

   // Pixel and configuration field widths.
   localparam int PIXEL_W      = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 12;
   localparam int ROW_COUNT_W  = 12;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_INDEX_BIT = 2;

   // Register reset values.
   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd64;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd64;

   // Result queue geometry; the depth is a power of two.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   // Register indexes of the configuration port.
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

endpackage

/* src/lbp_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lbp_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port and registered read; a read at the written address returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lbp_cell.sv */
// One window column cell: holds a column of pixels and compares it to the centre.
`timescale 1ns / 1ps

module lbp_cell #(
   parameter int SIDE = 3
) (
   input  logic                              clock,
   input  logic                              shift_en,
   input  logic [SIDE*lbp_pkg::PIXEL_W-1:0] col_in,
   input  logic [lbp_pkg::PIXEL_W-1:0]      centre,
   output logic [SIDE*lbp_pkg::PIXEL_W-1:0] col_out,
   output logic [SIDE-1:0]                   gt_bits
);

   import lbp_pkg::*;

   logic [SIDE*PIXEL_W-1:0] col_ff;

   // Take the neighbor's column whenever the window moves one step.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   // A bit is set where the pixel is strictly greater than the centre.
   always_comb begin
      for (int y = 0; y < SIDE; y++) begin
         gt_bits[y] = col_ff[y*PIXEL_W +: PIXEL_W] > centre;
      end
   end

   assign col_out = col_ff;

endmodule

/* src/lbp_square_window_coder.sv */
// Top level of the local binary pattern coder over a square window.
//
// Usage: grey pixels enter in raster order on the req_ stream, one per
// transfer. For every pixel position at least RADIUS away from each frame
// border, one pattern code leaves on the rsp_ stream; border positions give
// nothing. rsp_tlast marks the code of the bottom-right interior position.
// image_width and image_height are set through the csr_ port while the block
// is idle (byte addresses 0 and 4).
// A pixel passes the line-store and compare stages; its code then waits in the queue.
// Throughput: one pixel per cycle while req_tready is high, set by the single line-store
// word per column, which is read in the transfer cycle and written back in the next.
// A four-entry result queue decouples the two sides: req_tready drops only
// when the queue plus the codes still in the pipeline could fill it, so a
// stalled receiver holds the head code steady and input stops in turn.
// Reset clears the raster counters, the pipeline and the queue, and loads
// 64 x 64 into the size registers. The line store needs no clearing pass;
// every entry that a code uses has been written earlier in the frame.
`timescale 1ns / 1ps

module lbp_square_window_coder #(
   parameter int RADIUS    = 1,
   parameter int MAX_WIDTH = 1024,
   localparam int SIDE       = 2 * RADIUS + 1,
   localparam int CODE_BITS  = SIDE * SIDE - 1,
   localparam int RSP_DATA_W = ((CODE_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] pixel
   // Result stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_DATA_W-1:0]            rsp_tdata,   // pattern_code, zero padded
   output logic                             rsp_tlast,   // last_in_frame
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lbp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lbp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import lbp_pkg::*;

   localparam int STORE_ROWS = 2 * RADIUS;
   localparam int STORE_W    = STORE_ROWS * PIXEL_W;
   localparam int COL_VEC_W  = SIDE * PIXEL_W;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WLIM_W     = $clog2(MAX_WIDTH + 1);
   localparam int EW         = (WLIM_W > CFG_WIDTH_W) ? WLIM_W : CFG_WIDTH_W;
   localparam int RW         = ROW_COUNT_W + 1;
   localparam int CENTRE_IDX = RADIUS * SIDE + RADIUS;
   localparam int FULL_BITS  = SIDE * SIDE;
   localparam int CNT_W      = FIFO_PTR_W + 1;

   // Configuration registers.
   logic [CFG_WIDTH_W-1:0]  width_ff, width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff, height_in;
   logic                    csr_write;
   reg_index_type           csr_index;

   // Raster counters.
   logic [COL_W-1:0]       col_count_ff, col_count_in;
   logic [ROW_COUNT_W-1:0] row_count_ff, row_count_in;

   // Line-store stage.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_emit_ff, s1_emit_in;
   logic                   s1_last_ff, s1_last_in;
   logic [PIXEL_W-1:0]     s1_pixel_ff;
   logic [COL_W-1:0]       s1_addr_ff;
   logic                   byp_valid_ff, byp_valid_in;
   logic [STORE_W-1:0]     byp_word_ff;

   // Compare stage.
   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_last_ff;

   // Result queue.
   logic [CODE_BITS-1:0]   fifo_code_ff [FIFO_DEPTH];
   logic                   fifo_last_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push, pop;

   // Datapath signals.
   logic                   accept;
   logic [EW-1:0]          w_raw, w_eff;
   logic [RW-1:0]          h_eff;
   logic [EW-1:0]          col_next;
   logic [RW-1:0]          row_next;
   logic                   emit, last;
   logic [STORE_W-1:0]     ram_rd_data, rd_word, new_word;
   logic [COL_VEC_W-1:0]   col_vec;
   logic [COL_VEC_W-1:0]   cell_col [SIDE];
   logic [SIDE-1:0]        cell_gt [SIDE];
   logic [PIXEL_W-1:0]     centre;
   logic [FULL_BITS-1:0]   full_bits;
   logic [CODE_BITS-1:0]   code;
   logic [CNT_W-1:0]       in_flight;

   // Configuration port: writes complete in the access phase, reads are direct.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_INDEX_BIT]);

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      csr_prdata = '0;
      case (csr_index)
         REG_IMAGE_WIDTH: begin
            csr_prdata = CSR_DATA_W'(width_ff);
            if (csr_write) begin
               width_in = csr_pwdata[CFG_WIDTH_W-1:0];
            end
         end
         REG_IMAGE_HEIGHT: begin
            csr_prdata = CSR_DATA_W'(height_ff);
            if (csr_write) begin
               height_in = csr_pwdata[CFG_HEIGHT_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // Input acceptance leaves room in the queue for every code still in flight.
   assign in_flight  = count_ff + CNT_W'(s1_emit_ff) + CNT_W'(s2_valid_ff);
   assign req_tready = in_flight < CNT_W'(FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;

   // Effective frame size: width saturates at the store depth, zero acts as one.
   assign w_raw = EW'(width_ff);
   always_comb begin
      if (w_raw > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else if (w_raw == '0) begin
         w_eff = EW'(1);
      end else begin
         w_eff = w_raw;
      end
      h_eff = (height_ff == '0) ? RW'(1) : RW'(height_ff);
   end

   // Interior test and raster counter advance for the pixel in transfer.
   assign col_next = EW'(col_count_ff) + EW'(1);
   assign row_next = RW'(row_count_ff) + RW'(1);
   assign emit = (col_count_ff >= COL_W'(STORE_ROWS)) && (EW'(col_count_ff) < w_eff) &&
                 (row_count_ff >= ROW_COUNT_W'(STORE_ROWS)) && (RW'(row_count_ff) < h_eff);
   assign last = emit && (col_next == w_eff) && (row_next == h_eff);

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            col_count_in = '0;
            if (row_next >= h_eff) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_next[ROW_COUNT_W-1:0];
            end
         end else begin
            col_count_in = col_next[COL_W-1:0];
         end
      end
   end

   // Stage control: the pipeline never stalls past the transfer.
   assign s1_valid_in  = accept;
   assign s1_emit_in   = accept && emit;
   assign s1_last_in   = last;
   assign byp_valid_in = s1_valid_ff && (s1_addr_ff == col_count_ff);
   assign s2_valid_in  = s1_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s1_emit_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= s1_valid_in;
         s1_emit_ff   <= s1_emit_in;
         s2_valid_ff  <= s2_valid_in;
         byp_valid_ff <= byp_valid_in;
      end
   end

   // Payload registers of the line-store and compare stages.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_tdata[PIXEL_W-1:0];
         s1_addr_ff  <= col_count_ff;
         s1_last_ff  <= s1_last_in;
         byp_word_ff <= new_word;
      end
      s2_last_ff <= s1_last_ff;
   end

   // Column line store: one word per column holds the last rows of that column.
   lbp_ram #(
      .DATA_W (STORE_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (new_word),
      .rd_en   (accept),
      .rd_addr (col_count_ff),
      .rd_data (ram_rd_data)
   );

   // A write to the same column in the transfer cycle is forwarded past the RAM.
   assign rd_word  = byp_valid_ff ? byp_word_ff : ram_rd_data;
   assign col_vec  = {s1_pixel_ff, rd_word};
   assign new_word = col_vec[COL_VEC_W-1:PIXEL_W];

   // Window: a row of column cells, each passing its column to its left neighbor.
   assign centre = cell_col[RADIUS][RADIUS*PIXEL_W +: PIXEL_W];

   for (genvar x = 0; x < SIDE; x++) begin : g_cell
      logic [COL_VEC_W-1:0] feed;
      if (x == SIDE - 1) begin : g_edge
         assign feed = col_vec;
      end else begin : g_inner
         assign feed = cell_col[x+1];
      end
      lbp_cell #(
         .SIDE (SIDE)
      ) u_cell (
         .clock    (clock),
         .shift_en (s1_valid_ff),
         .col_in   (feed),
         .centre   (centre),
         .col_out  (cell_col[x]),
         .gt_bits  (cell_gt[x])
      );
   end

   // Gather compare bits in raster order and drop the centre position.
   always_comb begin
      for (int y = 0; y < SIDE; y++) begin
         for (int x = 0; x < SIDE; x++) begin
            full_bits[y*SIDE + x] = cell_gt[x][y];
         end
      end
   end
   assign code = {full_bits[FULL_BITS-1:CENTRE_IDX+1], full_bits[CENTRE_IDX-1:0]};

   // Result queue between the compare stage and the output stream.
   assign push      = s2_valid_ff;
   assign pop       = rsp_tvalid && rsp_tready;
   assign wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_code_ff[wr_ptr_ff] <= code;
         fifo_last_ff[wr_ptr_ff] <= s2_last_ff;
      end
   end

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = RSP_DATA_W'(fifo_code_ff[rd_ptr_ff]);
   assign rsp_tlast  = fifo_last_ff[rd_ptr_ff];

endmodule

/* src/lbp_checker.sv */
// Port-level checks for the window coder, bound to its top level.
`timescale 1ns / 1ps

module lbp_checker #(
   parameter int RSP_DATA_W = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // A result offered and not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its code and frame flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Reset empties the output side.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // An empty output fills only from an earlier pixel transfer through both pipeline stages.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result without a matching input transfer");

endmodule

bind lbp_square_window_coder lbp_checker #(
   .RSP_DATA_W (RSP_DATA_W)
) u_lbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* verif/lbp_code_checker.sv */
// Channel monitor that predicts and checks the pattern codes of the window coder.
`timescale 1ns / 1ps

module lbp_code_checker #(
   parameter int RADIUS    = 1,
   parameter int MAX_WIDTH = 1024,
   localparam int SIDE       = 2 * RADIUS + 1,
   localparam int STORE_ROWS = 2 * RADIUS,
   localparam int CODE_BITS  = SIDE * SIDE - 1,
   localparam int RSP_DATA_W = ((CODE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] pixel
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [RSP_DATA_W-1:0]               rsp_tdata,   // pattern_code, zero padded
   input  logic                                rsp_tlast,   // last_in_frame
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lbp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  codes_pending
);

   import lbp_pkg::*;

   typedef struct packed {
      logic [CODE_BITS-1:0] pattern_code;
      logic                 last_in_frame;
   } lbp_code_type;

   // Shadow of the size registers and of the block's raster state.
   logic [CFG_WIDTH_W-1:0]  image_width;
   logic [CFG_HEIGHT_W-1:0] image_height;
   logic [PIXEL_W-1:0]      line_store [STORE_ROWS][MAX_WIDTH];
   logic [PIXEL_W-1:0]      pixel_window [SIDE][SIDE];
   int unsigned             column_count;
   int unsigned             row_count;
   lbp_code_type            expected_codes [$];
   int                      failures;

   // Advances the raster state by one pixel and queues the code it produces, if any.
   task automatic predict_code(input logic [PIXEL_W-1:0] pixel);
      int unsigned        w;
      int unsigned        h;
      int unsigned        col;
      int                 bit_index;
      logic [PIXEL_W-1:0] column [SIDE];
      lbp_code_type       entry;
      w = (image_width > MAX_WIDTH) ? MAX_WIDTH : image_width;
      if (w == 0) begin
         w = 1;
      end
      h = (image_height == 0) ? 1 : image_height;
      col = column_count % MAX_WIDTH;

      // The column shifts up through the line store with the new pixel at the bottom.
      for (int k = 0; k < STORE_ROWS; k++) begin
         column[k] = line_store[k][col];
      end
      column[STORE_ROWS] = pixel;
      for (int k = 0; k < STORE_ROWS; k++) begin
         line_store[k][col] = column[k + 1];
      end

      // The window moves one column left and takes the new column on the right.
      for (int y = 0; y < SIDE; y++) begin
         for (int x = 0; x + 1 < SIDE; x++) begin
            pixel_window[y][x] = pixel_window[y][x + 1];
         end
         pixel_window[y][SIDE - 1] = column[y];
      end

      // Interior positions give one code: neighbors in raster order, centre skipped.
      if (column_count >= STORE_ROWS && column_count < w &&
          row_count >= STORE_ROWS && row_count < h) begin
         entry.pattern_code = '0;
         bit_index = 0;
         for (int y = 0; y < SIDE; y++) begin
            for (int x = 0; x < SIDE; x++) begin
               if (!(y == RADIUS && x == RADIUS)) begin
                  entry.pattern_code[bit_index] =
                     pixel_window[y][x] > pixel_window[RADIUS][RADIUS];
                  bit_index++;
               end
            end
         end
         entry.last_in_frame = (column_count == w - 1) && (row_count == h - 1);
         expected_codes.push_back(entry);
      end

      if (column_count + 1 >= w) begin
         column_count = 0;
         row_count = (row_count + 1 >= h) ? 0 : row_count + 1;
      end else begin
         column_count++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      lbp_code_type            want;
      reg_index_type           reg_index;
      logic [CSR_DATA_W-1:0]   reg_value;
      if (reset) begin
         image_width  = WIDTH_RESET;
         image_height = HEIGHT_RESET;
         column_count = 0;
         row_count    = 0;
         for (int y = 0; y < SIDE; y++) begin
            for (int x = 0; x < SIDE; x++) begin
               pixel_window[y][x] = '0;
            end
         end
         for (int k = 0; k < STORE_ROWS; k++) begin
            for (int c = 0; c < MAX_WIDTH; c++) begin
               line_store[k][c] = '0;
            end
         end
         expected_codes.delete();
      end else begin
         // Register writes update the shadow; reads are compared against it.
         reg_index = reg_index_type'(csr_paddr[CSR_INDEX_BIT]);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (reg_index)
                  REG_IMAGE_WIDTH: begin
                     image_width = csr_pwdata[CFG_WIDTH_W-1:0];
                  end
                  REG_IMAGE_HEIGHT: begin
                     image_height = csr_pwdata[CFG_HEIGHT_W-1:0];
                  end
                  default: begin
                  end
               endcase
            end else begin
               reg_value = (reg_index == REG_IMAGE_WIDTH) ? CSR_DATA_W'(image_width)
                                                          : CSR_DATA_W'(image_height);
               if (csr_prdata !== reg_value) begin
                  $error("register %s read: expected %0d, actual %0d",
                         reg_index.name(), reg_value, csr_prdata);
                  failures++;
               end
            end
         end

         // A code transfer is matched against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_codes.size() == 0) begin
               $error("unexpected code transfer: pattern_code %0h, last_in_frame %0b",
                      rsp_tdata[CODE_BITS-1:0], rsp_tlast);
               failures++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_tdata[CODE_BITS-1:0] !== want.pattern_code) begin
                  $error("pattern_code: expected %0h, actual %0h",
                         want.pattern_code, rsp_tdata[CODE_BITS-1:0]);
                  failures++;
               end
               if (rsp_tlast !== want.last_in_frame) begin
                  $error("last_in_frame: expected %0b, actual %0b",
                         want.last_in_frame, rsp_tlast);
                  failures++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            predict_code(req_tdata);
         end
      end
      codes_pending <= expected_codes.size();
      fail_count    <= failures;
   end

endmodule

/* verif/lbp_square_window_coder_tb.sv */
// Stimulus and verdict for the local binary pattern window coder.
`timescale 1ns / 1ps

module lbp_square_window_coder_tb;

   import lbp_pkg::*;

   localparam int RADIUS      = 1;
   localparam int MAX_WIDTH   = 1024;
   localparam int CODE_BITS   = (2 * RADIUS + 1) * (2 * RADIUS + 1) - 1;
   localparam int RSP_DATA_W  = ((CODE_BITS + 7) / 8) * 8;
   localparam int SETTLE      = 6;
   localparam int LONG_HOLD   = 400;
   localparam int STALL_LIMIT = 3000;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata   = '0;   // [7:0] pixel
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;          // pattern_code, zero padded
   logic                    rsp_tlast;          // last_in_frame
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int   fail_count;
   int   codes_pending;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_trigger  = 1'b0;
   logic hold_seen     = 1'b0;
   int   hold_left     = 0;
   int   stall_cycles  = 0;

   lbp_square_window_coder #(
      .RADIUS    (RADIUS),
      .MAX_WIDTH (MAX_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lbp_code_checker #(
      .RADIUS    (RADIUS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_code_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .codes_pending (codes_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Code receiver: random back-pressure, plus one long hold-off on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen  <= hold_trigger;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // One pixel transfer, with random idle cycles ahead of it.
   task automatic send_pixel(input logic [7:0] pixel);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Stops offering pixels and waits for every predicted code to arrive.
   task automatic drain_codes();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (codes_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // One register transfer; the caller releases the bus after the last one.
   task automatic csr_access(input logic is_write, input reg_index_type reg_index,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {{(CSR_ADDR_W - 1){1'b0}}, reg_index} << CSR_INDEX_BIT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
   endtask

   // Sizes change only with the block idle and the raster at a frame boundary.
   task automatic set_frame_size(input logic [CFG_WIDTH_W-1:0] w,
                                 input logic [CFG_HEIGHT_W-1:0] h);
      drain_codes();
      repeat (SETTLE) @(posedge clock);
      csr_access(1'b1, REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      csr_access(1'b1, REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
      csr_access(1'b0, REG_IMAGE_WIDTH, '0);
      csr_access(1'b0, REG_IMAGE_HEIGHT, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // A 3x3 frame whose neighbors take the upper value where the mask bit is set.
   task automatic send_window_frame(input logic [7:0] centre, input logic [7:0] upper,
                                    input logic [7:0] lower, input logic [7:0] mask);
      int k;
      for (int p = 0; p < 9; p++) begin
         k = (p < 4) ? p : p - 1;
         if (p == 4) begin
            send_pixel(centre);
         end else begin
            send_pixel(mask[k] ? upper : lower);
         end
      end
   endtask

   // Whole frames of random pixels, some drawn from a narrow range so ties occur.
   task automatic run_phase(input logic [CFG_WIDTH_W-1:0] w,
                            input logic [CFG_HEIGHT_W-1:0] h,
                            input int frames, input logic pressure);
      int unsigned cols;
      int unsigned rows;
      int unsigned total;
      logic        narrow;
      logic [7:0]  base;
      set_frame_size(w, h);
      cols  = (w > MAX_WIDTH) ? MAX_WIDTH : ((w == 0) ? 1 : w);
      rows  = (h == 0) ? 1 : h;
      total = cols * rows * frames;
      narrow = 1'b0;
      base   = '0;
      if (pressure) begin
         hold_trigger <= ~hold_trigger;
      end
      for (int unsigned n = 0; n < total; n++) begin
         if (n % (cols * rows) == 0) begin
            narrow = ($urandom_range(0, 2) == 0);
            base   = 8'($urandom_range(0, 253));
         end
         if (pressure && n == total / 2) begin
            drain_codes();
         end
         send_pixel(narrow ? 8'(base + $urandom_range(0, 2)) : 8'($urandom_range(0, 255)));
      end
   endtask

   // Mostly small interior frames, now and then a frame too thin for any code.
   task automatic random_phase();
      logic [CFG_WIDTH_W-1:0]  w;
      logic [CFG_HEIGHT_W-1:0] h;
      w = ($urandom_range(0, 9) == 0) ? CFG_WIDTH_W'($urandom_range(0, 2))
                                      : CFG_WIDTH_W'($urandom_range(3, 9));
      h = ($urandom_range(0, 9) == 0) ? CFG_HEIGHT_W'($urandom_range(0, 2))
                                      : CFG_HEIGHT_W'($urandom_range(3, 7));
      run_phase(w, h, int'($urandom_range(1, 2)), 1'b0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles lightly, receiver heavily.
      send_idle_pct = 21;
      recv_idle_pct <= 70;

      // Reset values read back, then directed 3x3 windows: all greater,
      // ties with the centre, and a mixed mask that pins down the bit order.
      csr_access(1'b0, REG_IMAGE_WIDTH, '0);
      csr_access(1'b0, REG_IMAGE_HEIGHT, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      set_frame_size(11'd3, 12'd3);
      send_window_frame(8'd0, 8'd255, 8'd255, 8'hFF);
      send_window_frame(8'd255, 8'd255, 8'd0, 8'h0F);
      send_window_frame(8'd128, 8'd129, 8'd127, 8'h5A);

      repeat (2) random_phase();
      run_phase(11'd0, 12'd0, 3, 1'b0);
      run_phase(11'd2, 12'd7, 1, 1'b0);
      run_phase(11'd8, 12'd6, 2, 1'b1);

      // Sender idles heavily, receiver lightly.
      send_idle_pct = 70;
      recv_idle_pct <= 21;
      repeat (2) random_phase();
      run_phase(11'd40, 12'd3, 1, 1'b0);
      run_phase(11'd5, 12'd1, 2, 1'b0);
      run_phase(11'd1, 12'd5, 2, 1'b0);

      // Neither side idles.
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      repeat (2) random_phase();
      run_phase(11'd3, 12'd20, 1, 1'b0);
      run_phase(11'd3, 12'd3, 3, 1'b0);

      drain_codes();
      repeat (SETTLE * 2) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
